### hdl/p2p_pkg.sv
// ----------------------------------------------------------------------------
// p2p_pkg: shared types and constants of the planar to palette rgb converter
// transaction layouts, configuration records, register and command codes
// ----------------------------------------------------------------------------
package p2p_pkg;

   // geometry
   localparam int PALETTE_ENTRIES = 16;
   localparam int PAL_IDX_W       = $clog2(PALETTE_ENTRIES);
   localparam int NUM_PIXELS      = 8;
   localparam int NUM_PLANES      = 4;
   localparam int CH_W            = 4;
   localparam int ENTRY_W         = 3 * CH_W;
   localparam int RGB_W           = 24;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_MASK  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UL_ENABLE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UL_COLOR    = 2'd2;

   localparam logic [NUM_PLANES-1:0] PLANE_MASK_RESET = 4'hf;

   // commands
   localparam logic CMD_PAL_WRITE = 1'b0;
   localparam logic CMD_CONVERT   = 1'b1;

   // request transaction
   typedef struct packed {
      logic       cmd;
      logic [7:0] plane_b;
      logic [7:0] plane_r;
      logic [7:0] plane_g;
      logic [7:0] plane_e;
      logic [3:0] pal_index;
      logic [3:0] pal_red;
      logic [3:0] pal_green;
      logic [3:0] pal_blue;
   } req_type;

   // response transaction
   typedef struct packed {
      logic [RGB_W-1:0] pixel0_rgb;
      logic [RGB_W-1:0] pixel1_rgb;
      logic [RGB_W-1:0] pixel2_rgb;
      logic [RGB_W-1:0] pixel3_rgb;
      logic [RGB_W-1:0] pixel4_rgb;
      logic [RGB_W-1:0] pixel5_rgb;
      logic [RGB_W-1:0] pixel6_rgb;
      logic [RGB_W-1:0] pixel7_rgb;
   } rsp_type;

   // configuration seen by the lanes
   typedef struct packed {
      logic [NUM_PLANES-1:0] plane_mask;
      logic                  ul_enable;
      logic [PAL_IDX_W-1:0]  ul_color;
   } cfg_type;

   // palette write broadcast to every lane copy
   typedef struct packed {
      logic                 en;
      logic [PAL_IDX_W-1:0] index;
      logic [ENTRY_W-1:0]   entry;
   } pal_wr_type;

   // 4-bit channel to 8 bits, same as multiplying by 17
   function automatic logic [2*CH_W-1:0] widen_channel(input logic [CH_W-1:0] v);
      return {v, v};
   endfunction

endpackage

### hdl/planar_to_palette_rgb_top.sv
// ----------------------------------------------------------------------------
// planar_to_palette_rgb_top: four-bitplane to chunky rgb converter
// eight lanes build color indices and look up replicated palettes
// ----------------------------------------------------------------------------
// Throughput is one transaction per clock: a convert transaction is accepted
// every cycle while the response side keeps taking results, and a palette
// write produces no response. A convert response passes through the
// registered palette read in each of the eight pixel lanes and then the
// output register. Each lane holds its own copy of the 16-entry palette, so
// all eight pixels read in the same cycle; a palette write updates every copy
// at once and is seen by the very next transaction. Unwritten palette entries
// read as black after reset, no clearing pass is needed.
module planar_to_palette_rgb_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  p2p_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output p2p_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [p2p_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [p2p_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import p2p_pkg::*;

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   pal_wr_type           pal_wr;
   logic                 req_fire;
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic                 s1_ready;
   logic                 advance;
   logic [NUM_PLANES-1:0] lane_bits [NUM_PIXELS];
   logic [ENTRY_W-1:0]   lane_entry [NUM_PIXELS];

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PLANE_MASK: cfg_in.plane_mask = csr_wdata[NUM_PLANES-1:0];
            CSR_UL_ENABLE:  cfg_in.ul_enable  = csr_wdata[0];
            CSR_UL_COLOR:   cfg_in.ul_color   = csr_wdata[PAL_IDX_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.plane_mask <= PLANE_MASK_RESET;
         cfg_ff.ul_enable  <= 1'b0;
         cfg_ff.ul_color   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input handshake
   assign s1_ready  = !s1_valid_ff || advance;
   assign req_ready = s1_ready;
   assign req_fire  = req_valid && req_ready;

   // palette write broadcast
   assign pal_wr.en    = req_fire && (req_data.cmd == CMD_PAL_WRITE);
   assign pal_wr.index = req_data.pal_index;
   assign pal_wr.entry = {req_data.pal_red, req_data.pal_green, req_data.pal_blue};

   // lane read stage valid
   assign s1_valid_in = s1_ready ? (req_fire && (req_data.cmd == CMD_CONVERT))
                                 : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // pixel lanes, leftmost pixel from bit 7
   for (genvar k = 0; k < NUM_PIXELS; k++) begin : g_lane
      assign lane_bits[k] = {req_data.plane_e[NUM_PIXELS-1-k],
                             req_data.plane_g[NUM_PIXELS-1-k],
                             req_data.plane_r[NUM_PIXELS-1-k],
                             req_data.plane_b[NUM_PIXELS-1-k]};

      p2p_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .plane_bits (lane_bits[k]),
         .cfg        (cfg_ff),
         .pal_wr     (pal_wr),
         .rd_en      (s1_ready),
         .entry      (lane_entry[k])
      );
   end

   // merge and output register
   p2p_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .s1_valid   (s1_valid_ff),
      .lane_entry (lane_entry),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   // a palette write never enters the result path
   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.cmd == CMD_PAL_WRITE) |=> !s1_valid_ff)
      else $error("palette write produced a lane stage transaction");

   // a convert always occupies the lane stage next cycle
   a_convert_enters: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.cmd == CMD_CONVERT) |=> s1_valid_ff)
      else $error("convert transaction lost at lane stage");

   // a blocked lane stage keeps its read data
   a_lane_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(lane_entry[0])
                                     && $stable(lane_entry[NUM_PIXELS-1])))
      else $error("stalled lane data changed");

   // both stages full and stalled means no new request
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request accepted with full pipeline");

endmodule

### hdl/p2p_lane.sv
// ----------------------------------------------------------------------------
// p2p_lane: one pixel lane
// forms the color index from four plane bits and reads its own palette copy
// ----------------------------------------------------------------------------
module p2p_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [p2p_pkg::NUM_PLANES-1:0] plane_bits,
   input  p2p_pkg::cfg_type              cfg,
   input  p2p_pkg::pal_wr_type           pal_wr,
   input  logic                          rd_en,
   output logic [p2p_pkg::ENTRY_W-1:0]   entry
);
   import p2p_pkg::*;

   logic [ENTRY_W-1:0]         pal_mem_ff [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] vld_ff;
   logic [PALETTE_ENTRIES-1:0] vld_in;
   logic [ENTRY_W-1:0]         rd_data_ff;
   logic                       rd_vld_ff;
   logic [PAL_IDX_W-1:0]       raw_idx;
   logic [PAL_IDX_W-1:0]       idx;

   // masked planes, underlay color replaces index zero when enabled
   always_comb begin
      raw_idx = plane_bits & cfg.plane_mask;
      if (raw_idx == '0 && cfg.ul_enable) begin
         idx = cfg.ul_color;
      end else begin
         idx = raw_idx;
      end
   end

   // palette copy storage
   always_ff @(posedge clock) begin
      if (pal_wr.en) begin
         pal_mem_ff[pal_wr.index] <= pal_wr.entry;
      end
   end

   // written-entry flags, an unwritten entry reads as black
   always_comb begin
      vld_in = vld_ff;
      if (pal_wr.en) begin
         vld_in[pal_wr.index] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= pal_mem_ff[idx];
         rd_vld_ff  <= vld_ff[idx];
      end
   end

   assign entry = rd_vld_ff ? rd_data_ff : '0;

endmodule

### hdl/p2p_merge.sv
// ----------------------------------------------------------------------------
// p2p_merge: output stage
// widens the lane entries to 24-bit pixels and holds the response transaction
// ----------------------------------------------------------------------------
module p2p_merge (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        s1_valid,
   input  logic [p2p_pkg::ENTRY_W-1:0] lane_entry [p2p_pkg::NUM_PIXELS],
   output logic                        advance,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output p2p_pkg::rsp_type            rsp_data
);
   import p2p_pkg::*;

   logic [RGB_W-1:0] pix [NUM_PIXELS];
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_data_ff;
   rsp_type          rsp_data_in;

   // expand each channel of every lane
   always_comb begin
      for (int k = 0; k < NUM_PIXELS; k++) begin
         pix[k] = {widen_channel(lane_entry[k][ENTRY_W-1 -: CH_W]),
                   widen_channel(lane_entry[k][2*CH_W-1 -: CH_W]),
                   widen_channel(lane_entry[k][CH_W-1:0])};
      end
      rsp_data_in.pixel0_rgb = pix[0];
      rsp_data_in.pixel1_rgb = pix[1];
      rsp_data_in.pixel2_rgb = pix[2];
      rsp_data_in.pixel3_rgb = pix[3];
      rsp_data_in.pixel4_rgb = pix[4];
      rsp_data_in.pixel5_rgb = pix[5];
      rsp_data_in.pixel6_rgb = pix[6];
      rsp_data_in.pixel7_rgb = pix[7];
   end

   // output register moves when empty or drained
   assign advance      = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = advance ? s1_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
